// ===== rtl/core/assert_macros.svh =====
// Assertion helpers, clocked on clk, disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property that must hold on every enabled clock edge.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent and consequent joined by an overlapping implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mtt_pkg.sv =====
package mtt_pkg;

  localparam int RAW_BITS    = 10;
  localparam int LAP_BITS    = 3;
  localparam int MLAP_BITS   = 4;
  localparam int FRAC_BITS   = 16;
  localparam int POS_BITS    = RAW_BITS + LAP_BITS;
  localparam int STEP_BITS   = 2;
  localparam int LAP_LIMIT   = 8;
  localparam int EDGE_MARGIN = 75;
  localparam int MLAP_RESET  = 3;

  localparam int IN_DATA_W   = 16;
  localparam int OUT_FIELDS_W = RAW_BITS + LAP_BITS + POS_BITS + FRAC_BITS + STEP_BITS;
  localparam int OUT_DATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int CFG_DATA_W  = 10;
  localparam int CFG_IDX_W   = 1;
  localparam int CNT_BITS    = $clog2(FRAC_BITS);

  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_SET_LAP = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LAPS    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET = 1'b1;

  localparam logic [STEP_BITS-1:0] STEP_NONE = 2'd0;
  localparam logic [STEP_BITS-1:0] STEP_ADV  = 2'd1;
  localparam logic [STEP_BITS-1:0] STEP_BACK = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic take;
    logic prep;
    logic step;
    logic emit;
  } cmd_t;

endpackage

// ===== rtl/core/multiturn_encoder_tracker.sv =====
// Multi-turn lap tracker for an absolute encoder.
// Flow: an accepted transaction passes through offset setup (ST_PREP), a
// 16-step restoring division of the turn fraction (ST_DIV) and the output load
// (ST_EMIT); a new transaction is accepted only in ST_IDLE, after the divider
// loop is done, and the load waits longer while a result waits on out_tready.
// Reset (rst_n low, synchronous): laps 0, no prior sample, max_laps 3, offset 0.
module multiturn_encoder_tracker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [9:0] raw_reading, [12:10] lap_value, [15:13] zero
  input  logic [mtt_pkg::IN_DATA_W-1:0]      in_tdata,
  // [0] operation
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [9:0] raw_position, [12:10] lap, [25:13] position, [41:26] turn_fraction,
  // [43:42] lap_step, [47:44] zero
  output logic [mtt_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mtt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mtt_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mtt_pkg::*;

  `include "assert_macros.svh"

  cmd_t                 cmd;
  logic [STEP_BITS-1:0] out_step;

  assign cfg_ready = 1'b1;
  assign out_step  = out_tdata[OUT_FIELDS_W-1 -: STEP_BITS];

  mtt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  mtt_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_op     (in_tuser),
    .in_raw    (in_tdata[RAW_BITS-1:0]),
    .in_lap    (in_tdata[RAW_BITS+LAP_BITS-1:RAW_BITS]),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .out_data  (out_tdata)
  );

  `ASSERT_IMPLIES(a_one_in_flight, in_tvalid && in_tready, ##1 !in_tready, "accepted while busy")

  `ASSERT_IMPLIES(a_result_ready, in_tvalid && in_tready, ##19 out_tvalid, "no result after divide")

  `ASSERT_ALWAYS(a_step_code, !out_tvalid || out_step <= STEP_BACK, "bad lap_step code")

endmodule

// ===== rtl/core/mtt_ctrl.sv =====
module mtt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output mtt_pkg::cmd_t cmd
);
  import mtt_pkg::*;

  state_t              state_r, state_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    in_tready     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.take  = 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_BITS'(FRAC_BITS - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

// ===== rtl/core/mtt_datapath.sv =====
module mtt_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mtt_pkg::cmd_t                   cmd,
  input  logic                            in_op,
  input  logic [mtt_pkg::RAW_BITS-1:0]    in_raw,
  input  logic [mtt_pkg::LAP_BITS-1:0]    in_lap,
  input  logic                            cfg_wr,
  input  logic [mtt_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [mtt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output logic [mtt_pkg::OUT_DATA_W-1:0]  out_data
);
  import mtt_pkg::*;

  localparam int HI_BAND = (1 << RAW_BITS) - EDGE_MARGIN;
  localparam int PAD_W   = OUT_DATA_W - OUT_FIELDS_W;
  localparam int SHIFT_W = FRAC_BITS - RAW_BITS;

  function automatic logic [MLAP_BITS-1:0] mod_small(input logic [MLAP_BITS-1:0] a,
                                                     input logic [MLAP_BITS-1:0] d);
    logic [MLAP_BITS-1:0] r;
    logic [MLAP_BITS:0]   t;
    r = '0;
    for (int i = MLAP_BITS - 1; i >= 0; i--) begin
      t = {r, a[i]};
      if (t >= {1'b0, d}) r = MLAP_BITS'(t - {1'b0, d});
      else r = t[MLAP_BITS-1:0];
    end
    return r;
  endfunction

  logic [MLAP_BITS-1:0] max_laps_r, max_laps_nxt;
  logic [RAW_BITS-1:0]  zero_off_r, zero_off_nxt;
  logic [RAW_BITS-1:0]  prev_r, prev_nxt;
  logic                 have_prev_r, have_prev_nxt;
  logic [LAP_BITS-1:0]  lap_r, lap_nxt;
  logic [STEP_BITS-1:0] step_r, step_nxt;
  logic [MLAP_BITS-1:0] rem_r, rem_nxt;
  logic [FRAC_BITS-1:0] dvd_r, dvd_nxt;
  logic [OUT_DATA_W-1:0] out_r, out_nxt;

  logic [MLAP_BITS-1:0] m_eff;
  logic [LAP_BITS-1:0]  m_last;
  logic                 cur_hi, cur_lo, prv_hi, prv_lo;
  logic [RAW_BITS:0]    diff;
  logic [MLAP_BITS-1:0] hi_sum;
  logic [MLAP_BITS:0]   trial;
  logic                 ge;
  logic [POS_BITS-1:0]  pos;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_laps_r  <= MLAP_BITS'(MLAP_RESET);
      zero_off_r  <= '0;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      lap_r       <= '0;
    end else begin
      max_laps_r  <= max_laps_nxt;
      zero_off_r  <= zero_off_nxt;
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
      lap_r       <= lap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    out_r  <= out_nxt;
  end

  always_comb begin
    if (max_laps_r == '0) m_eff = MLAP_BITS'(1);
    else if (max_laps_r > MLAP_BITS'(LAP_LIMIT)) m_eff = MLAP_BITS'(LAP_LIMIT);
    else m_eff = max_laps_r;
  end

  assign m_last = LAP_BITS'(m_eff - 1'b1);

  always_comb begin
    max_laps_nxt = max_laps_r;
    zero_off_nxt = zero_off_r;
    if (cfg_wr) begin
      case (cfg_idx)
        CFG_MAX_LAPS:    max_laps_nxt = cfg_wdata[MLAP_BITS-1:0];
        CFG_ZERO_OFFSET: zero_off_nxt = cfg_wdata[RAW_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cur_hi = in_raw >= RAW_BITS'(HI_BAND);
  assign cur_lo = in_raw <= RAW_BITS'(EDGE_MARGIN);
  assign prv_hi = prev_r >= RAW_BITS'(HI_BAND);
  assign prv_lo = prev_r <= RAW_BITS'(EDGE_MARGIN);

  // lap tracking on each accepted transaction
  always_comb begin
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    lap_nxt       = lap_r;
    step_nxt      = step_r;
    if (cmd.take) begin
      step_nxt = STEP_NONE;
      if (in_op == OP_SET_LAP) begin
        if ({1'b0, in_lap} < m_eff) lap_nxt = in_lap;
      end else begin
        if (have_prev_r && (m_eff > MLAP_BITS'(1))) begin
          if (cur_lo && prv_hi) begin
            lap_nxt  = (lap_r >= m_last) ? '0 : lap_r + 1'b1;
            step_nxt = STEP_ADV;
          end else if (prv_lo && cur_hi) begin
            lap_nxt  = ((lap_r == '0) || (lap_r > m_last)) ? m_last : lap_r - 1'b1;
            step_nxt = STEP_BACK;
          end
        end
        prev_nxt      = in_raw;
        have_prev_nxt = 1'b1;
      end
    end
  end

  // offset correction, then restoring division of corr * 2^SHIFT_W by m_eff
  assign diff   = {1'b0, prev_r} - {1'b0, zero_off_r};
  assign hi_sum = MLAP_BITS'(lap_r) + m_eff - MLAP_BITS'(diff[RAW_BITS]);
  assign trial  = {rem_r, dvd_r[FRAC_BITS-1]};
  assign ge     = trial >= {1'b0, m_eff};

  always_comb begin
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    if (cmd.prep) begin
      rem_nxt = mod_small(hi_sum, m_eff);
      dvd_nxt = {diff[RAW_BITS-1:0], {SHIFT_W{1'b0}}};
    end else if (cmd.step) begin
      rem_nxt = ge ? MLAP_BITS'(trial - {1'b0, m_eff}) : trial[MLAP_BITS-1:0];
      dvd_nxt = {dvd_r[FRAC_BITS-2:0], ge};
    end
  end

  assign pos = (m_eff <= MLAP_BITS'(1)) ? {{LAP_BITS{1'b0}}, prev_r} : {lap_r, prev_r};

  always_comb begin
    out_nxt = out_r;
    if (cmd.emit) begin
      out_nxt = {{PAD_W{1'b0}}, step_r, dvd_r, pos, lap_r, prev_r};
    end
  end

  assign out_data = out_r;

endmodule

// ===== verif/tb_multiturn_encoder_tracker.sv =====
module tb_multiturn_encoder_tracker;
  import mtt_pkg::*;

  localparam int RAW_RANGE      = 1 << RAW_BITS;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TAIL_CYCLES    = 48;
  localparam int N_DIRECTED     = 17;
  localparam int N_PHASES       = 10;
  localparam int ITEMS_PER_PHASE = 79;

  typedef struct packed {
    logic [STEP_BITS-1:0] step;
    logic [FRAC_BITS-1:0] frac;
    logic [POS_BITS-1:0]  pos;
    logic [LAP_BITS-1:0]  lap;
    logic [RAW_BITS-1:0]  raw;
  } track_result_t;

  typedef struct packed {
    logic                op;
    logic [RAW_BITS-1:0] raw;
    logic [LAP_BITS-1:0] lapv;
    logic                typed;
    track_result_t       want;
  } stim_row_t;

  // reset config: 3 laps, offset 0
  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{OP_SAMPLE,  10'd1023, 3'd0, 1'b1, '{STEP_NONE, 16'd21824, 13'd1023, 3'd0, 10'd1023}},
    '{OP_SAMPLE,  10'd0,    3'd0, 1'b1, '{STEP_ADV,  16'd21845, 13'd1024, 3'd1, 10'd0}},
    '{OP_SAMPLE,  10'd949,  3'd0, 1'b0, '0},
    '{OP_SAMPLE,  10'd75,   3'd0, 1'b0, '0},
    '{OP_SAMPLE,  10'd950,  3'd0, 1'b0, '0},
    '{OP_SAMPLE,  10'd948,  3'd0, 1'b0, '0},
    '{OP_SAMPLE,  10'd76,   3'd0, 1'b0, '0},
    '{OP_SAMPLE,  10'd74,   3'd0, 1'b0, '0},
    '{OP_SAMPLE,  10'd1023, 3'd0, 1'b0, '0},
    '{OP_SAMPLE,  10'd0,    3'd0, 1'b0, '0},
    '{OP_SET_LAP, 10'd0,    3'd2, 1'b0, '0},
    '{OP_SET_LAP, 10'd0,    3'd3, 1'b0, '0},
    '{OP_SET_LAP, 10'd1023, 3'd7, 1'b0, '0},
    '{OP_SET_LAP, 10'd0,    3'd0, 1'b0, '0},
    '{OP_SAMPLE,  10'd1023, 3'd7, 1'b0, '0},
    '{OP_SAMPLE,  10'd0,    3'd5, 1'b0, '0},
    '{OP_SET_LAP, 10'd512,  3'd1, 1'b0, '0}
  };

  localparam int PHASE_LAPS   [N_PHASES] = '{1, 8, 2, 0, 15, 8, 2, 5, 3, 7};
  localparam int PHASE_OFFSET [N_PHASES] = '{0, 1023, 512, 300, 1, 77, 0, 1000, 600, 949};

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  multiturn_encoder_tracker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // tracker model state and registers
  logic [RAW_BITS-1:0]   seen_reading;
  logic                  have_reading;
  logic [LAP_BITS-1:0]   lap_counter;
  logic [MLAP_BITS-1:0]  laps_reg;
  logic [RAW_BITS-1:0]   offset_reg;

  track_result_t expected_positions [$];
  logic          item_typed;
  track_result_t item_want;
  int            mismatch_count;
  int            quiet_cycles;
  bit            idle_on;
  bit            hold_req;

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic track_result_t track_encoder(input logic op,
                                                  input logic [RAW_BITS-1:0] raw,
                                                  input logic [LAP_BITS-1:0] lapv);
    int unsigned   laps;
    int unsigned   full;
    int unsigned   corr;
    logic [STEP_BITS-1:0] step;
    bit            cur_hi, cur_lo, prv_hi, prv_lo;
    track_result_t r;
    laps = (laps_reg == 0) ? 1 : (laps_reg > LAP_LIMIT) ? LAP_LIMIT : laps_reg;
    step = STEP_NONE;
    if (op == OP_SET_LAP) begin
      if (lapv < laps) lap_counter = lapv;
    end else begin
      if (have_reading && laps > 1) begin
        cur_hi = raw >= RAW_RANGE - EDGE_MARGIN;
        cur_lo = raw <= EDGE_MARGIN;
        prv_hi = seen_reading >= RAW_RANGE - EDGE_MARGIN;
        prv_lo = seen_reading <= EDGE_MARGIN;
        if (cur_lo && prv_hi) begin
          lap_counter = (lap_counter >= laps - 1) ? '0 : LAP_BITS'(lap_counter + 1);
          step = STEP_ADV;
        end else if (prv_lo && cur_hi) begin
          if (lap_counter == 0 || lap_counter > laps - 1) lap_counter = LAP_BITS'(laps - 1);
          else lap_counter = LAP_BITS'(lap_counter - 1);
          step = STEP_BACK;
        end
      end
      seen_reading = raw;
      have_reading = 1'b1;
    end
    full = laps * RAW_RANGE;
    corr = (lap_counter * RAW_RANGE + seen_reading + full - offset_reg) % full;
    r.raw  = seen_reading;
    r.lap  = lap_counter;
    r.pos  = (laps <= 1) ? POS_BITS'(seen_reading)
                         : POS_BITS'(seen_reading + lap_counter * RAW_RANGE);
    r.frac = FRAC_BITS'((corr << FRAC_BITS) / full);
    r.step = step;
    return r;
  endfunction

  task automatic flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endtask

  // transaction monitor: predicts on input accept, checks on output accept
  always @(posedge clk) begin
    track_result_t want;
    track_result_t got;
    track_result_t predicted;
    if (rst_n) begin
      quiet_cycles++;
      if (cfg_valid && cfg_ready) begin
        quiet_cycles = 0;
        case (cfg_index)
          CFG_MAX_LAPS:    laps_reg = cfg_data[MLAP_BITS-1:0];
          CFG_ZERO_OFFSET: offset_reg = cfg_data[RAW_BITS-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        quiet_cycles = 0;
        predicted = track_encoder(in_tuser, in_tdata[RAW_BITS-1:0],
                                  in_tdata[RAW_BITS+LAP_BITS-1:RAW_BITS]);
        expected_positions.push_back(item_typed ? item_want : predicted);
      end
      if (out_tvalid && out_tready) begin
        quiet_cycles = 0;
        got = track_result_t'(out_tdata[OUT_FIELDS_W-1:0]);
        if (expected_positions.size() == 0) begin
          flag_error($sformatf("unexpected result raw=%0d lap=%0d pos=%0d frac=%0d step=%0d",
                               got.raw, got.lap, got.pos, got.frac, got.step));
        end else begin
          want = expected_positions.pop_front();
          if (got.raw != want.raw || got.lap != want.lap || got.pos != want.pos ||
              got.frac != want.frac || got.step != want.step)
            flag_error($sformatf(
              {"mismatch: exp raw=%0d lap=%0d pos=%0d frac=%0d step=%0d, ",
               "got raw=%0d lap=%0d pos=%0d frac=%0d step=%0d"},
              want.raw, want.lap, want.pos, want.frac, want.step,
              got.raw, got.lap, got.pos, got.frac, got.step));
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // result receiver: random stall bursts and one long hold-off
  initial begin
    int burst;
    burst = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_tready = 1'b1;
      end else if (burst > 0) begin
        out_tready = 1'b0;
        burst--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_tready = 1'b0;
        burst = $urandom_range(0, 6);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  task automatic send_item(input stim_row_t row);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid  = 1'b1;
    in_tuser   = row.op;
    in_tdata   = {{(IN_DATA_W - RAW_BITS - LAP_BITS){1'b0}}, row.lapv, row.raw};
    item_typed = row.typed;
    item_want  = row.want;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (expected_positions.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    stim_row_t row;
    int        sel;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    item_typed   = 1'b0;
    item_want    = '0;
    idle_on      = 1'b1;
    hold_req     = 1'b0;
    seen_reading = '0;
    have_reading = 1'b0;
    lap_counter  = '0;
    laps_reg     = MLAP_BITS'(MLAP_RESET);
    offset_reg   = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) send_item(DIRECTED_ROWS[i]);
    wait_drained();

    for (int p = 0; p < N_PHASES; p++) begin
      write_reg(CFG_MAX_LAPS, CFG_DATA_W'(PHASE_LAPS[p]));
      write_reg(CFG_ZERO_OFFSET, CFG_DATA_W'(PHASE_OFFSET[p]));
      if (p == 1) hold_req = 1'b1;
      if (p == N_PHASES - 1) idle_on = 1'b0;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        sel      = $urandom_range(0, 99);
        row      = '0;
        row.op   = OP_SAMPLE;
        row.raw  = RAW_BITS'($urandom_range(0, RAW_RANGE - 1));
        row.lapv = LAP_BITS'($urandom_range(0, 7));
        if (sel < 10) row.op = OP_SET_LAP;
        else if (sel < 42)
          row.raw = RAW_BITS'($urandom_range(RAW_RANGE - EDGE_MARGIN, RAW_RANGE - 1));
        else if (sel < 74) row.raw = RAW_BITS'($urandom_range(0, EDGE_MARGIN));
        else if (sel < 82) begin
          case ($urandom_range(0, 7))
            0: row.raw = '0;
            1: row.raw = RAW_BITS'(EDGE_MARGIN - 1);
            2: row.raw = RAW_BITS'(EDGE_MARGIN);
            3: row.raw = RAW_BITS'(EDGE_MARGIN + 1);
            4: row.raw = RAW_BITS'(RAW_RANGE - EDGE_MARGIN - 1);
            5: row.raw = RAW_BITS'(RAW_RANGE - EDGE_MARGIN);
            6: row.raw = RAW_BITS'(RAW_RANGE - EDGE_MARGIN + 1);
            default: row.raw = RAW_BITS'(RAW_RANGE - 1);
          endcase
        end
        send_item(row);
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_positions.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
